// ===== hdl/sparse_matrix_vector_multiply_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the sparse matrix-vector multiply block
// Clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef SPARSE_MATRIX_VECTOR_MULTIPLY_MACROS_SVH
`define SPARSE_MATRIX_VECTOR_MULTIPLY_MACROS_SVH

// General clocked property
`define SMVM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Signal holds for the cycle after a stalled beat
`define SMVM_ASSERT_HOLD(label, vld, rdy, sig, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (vld && !rdy) |=> $stable(sig)) else $error(msg);

`endif

// ===== hdl/smvm_pkg.sv =====
// ---------------------------------------------------------------------------
// smvm_pkg
// Shared types and constants of the sparse matrix-vector multiply block.
// ---------------------------------------------------------------------------
package smvm_pkg;

    // item kinds
    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_NZ    = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;

    localparam int COL_W       = 10;
    localparam int VAL_W       = 32;
    localparam int ROWIDX_W    = 16;
    localparam int ACC_W       = 64;
    localparam int IN_TDATA_W  = 48;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 48;
    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_AW     = 3;

    // item entering the multiply pipeline
    typedef struct packed {
        logic                    valid;
        logic                    is_nz;
        logic signed [VAL_W-1:0] value;
        logic                    row_end;
        logic                    last_row;
        logic                    in_range;
    } item_t;

    // closed row, before rounding
    typedef struct packed {
        logic                    valid;
        logic [ROWIDX_W-1:0]     row_index;
        logic signed [ACC_W-1:0] acc;
        logic                    ovf;
        logic                    last;
    } fin_t;

    // result beat
    typedef struct packed {
        logic [ROWIDX_W-1:0]     row_index;
        logic signed [VAL_W-1:0] row_sum;
        logic                    saturated;
        logic                    last;
    } beat_t;

endpackage

// ===== hdl/sparse_matrix_vector_multiply.sv =====
// ---------------------------------------------------------------------------
// sparse_matrix_vector_multiply
// A row-closing beat passes the item, product and row result registers into the result queue.
// Throughput: one beat per cycle unless stalled; the vector store takes one access per beat.
// Input ready drops when queued results plus beats in the three stages reach 8.
// Reset clears pipeline, accumulator, row counter and queue; the vector store is not cleared.
// ---------------------------------------------------------------------------
module sparse_matrix_vector_multiply #(
    parameter int VECTOR_DEPTH = 1024,
    parameter int MAX_ROWS     = 65536
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [smvm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // col_index, entry_value
    input  logic [smvm_pkg::IN_TUSER_W-1:0]     s_axis_tuser,  // kind, last_row
    input  logic                                s_axis_tlast,  // row_end
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [smvm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // row_index, row_sum
    output logic                                m_axis_tuser,  // saturated
    output logic                                m_axis_tlast   // last
);
    import smvm_pkg::*;

    localparam int AW    = $clog2(VECTOR_DEPTH);
    localparam int CW    = (AW > COL_W) ? AW : COL_W;
    localparam int OCC_W = FIFO_AW + 2;
    localparam logic [16:0] DEPTH_W = 17'(VECTOR_DEPTH);

    logic [1:0]              in_kind;
    logic [COL_W-1:0]        in_col;
    logic signed [VAL_W-1:0] in_value;
    logic                    in_last_row;
    logic [CW-1:0]           col_wide;
    logic [AW-1:0]           addr;
    logic                    in_range;
    logic                    accept;
    logic                    vec_we;

    item_t                   item_reg;
    item_t                   item_next;
    logic [VAL_W-1:0]        x_data;
    logic                    prod_valid;
    fin_t                    fin;
    beat_t                   round_beat;
    beat_t                   out_beat;
    logic [FIFO_AW:0]        fifo_count;
    logic [OCC_W-1:0]        occupancy;

    assign in_col      = s_axis_tdata[COL_W-1:0];
    assign in_value    = s_axis_tdata[COL_W+VAL_W-1:COL_W];
    assign in_kind     = s_axis_tuser[1:0];
    assign in_last_row = s_axis_tuser[2];

    assign col_wide = CW'(in_col);
    assign addr     = col_wide[AW-1:0];
    assign in_range = (17'(in_col) < DEPTH_W);

    // every stage ahead of the queue may still turn into a result
    assign occupancy = OCC_W'(fifo_count) + OCC_W'(item_reg.valid)
                     + OCC_W'(prod_valid) + OCC_W'(fin.valid);
    assign s_axis_tready = (occupancy < OCC_W'(FIFO_DEPTH));
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign vec_we        = accept && (in_kind == KIND_LOAD) && in_range;

    always_comb
    begin
        item_next.valid    = accept && ((in_kind == KIND_NZ) || (in_kind == KIND_EMPTY));
        item_next.is_nz    = (in_kind == KIND_NZ);
        item_next.value    = in_value;
        item_next.row_end  = s_axis_tlast;
        item_next.last_row = in_last_row;
        item_next.in_range = in_range;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_reg <= '0;
        end
        else
        begin
            item_reg <= item_next;
        end
    end

    smvm_vec_mem #(
        .DEPTH (VECTOR_DEPTH),
        .AW    (AW)
    ) u_vec_mem (
        .clk   (clk),
        .we    (vec_we),
        .waddr (addr),
        .wdata (in_value),
        .raddr (addr),
        .rdata (x_data)
    );

    smvm_mac #(
        .MAX_ROWS (MAX_ROWS)
    ) u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item_reg),
        .x          (x_data),
        .prod_valid (prod_valid),
        .fin        (fin)
    );

    smvm_round u_round (
        .fin  (fin),
        .beat (round_beat)
    );

    smvm_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fin.valid),
        .push_beat (round_beat),
        .pop       (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_beat  (out_beat),
        .count     (fifo_count)
    );

    assign m_axis_tdata = {out_beat.row_sum, out_beat.row_index};
    assign m_axis_tuser = out_beat.saturated;
    assign m_axis_tlast = out_beat.last;

endmodule

// ===== hdl/smvm_vec_mem.sv =====
// ---------------------------------------------------------------------------
// smvm_vec_mem
// Dense vector store: one write port, one registered read port.
// ---------------------------------------------------------------------------
module smvm_vec_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                   clk,
    input  logic                   we,
    input  logic [AW-1:0]          waddr,
    input  logic [smvm_pkg::VAL_W-1:0] wdata,
    input  logic [AW-1:0]          raddr,
    output logic [smvm_pkg::VAL_W-1:0] rdata
);
    import smvm_pkg::*;

    logic [VAL_W-1:0] mem [DEPTH];
    logic [VAL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/smvm_mac.sv =====
// ---------------------------------------------------------------------------
// smvm_mac
// Multiply stage and saturating Q32.32 row accumulator with row counter.
// ---------------------------------------------------------------------------
module smvm_mac #(
    parameter int MAX_ROWS = 65536
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  smvm_pkg::item_t               item,
    input  logic signed [smvm_pkg::VAL_W-1:0] x,
    output logic                          prod_valid,
    output smvm_pkg::fin_t                fin
);
    import smvm_pkg::*;

    localparam int RW = $clog2(MAX_ROWS);
    localparam int IW = (RW > ROWIDX_W) ? RW : ROWIDX_W;
    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // product stage
    logic                    p_valid_reg;
    logic                    p_nz_reg;
    logic                    p_end_reg;
    logic                    p_last_reg;
    logic signed [ACC_W-1:0] prod_reg;
    logic signed [ACC_W-1:0] prod_next;

    // accumulate stage
    logic signed [ACC_W-1:0] acc_reg;
    logic                    ovf_reg;
    logic [RW-1:0]           cnt_reg;
    logic [RW-1:0]           cnt_next;
    logic [IW-1:0]           cnt_wide;
    fin_t                    fin_reg;
    fin_t                    fin_next;

    logic signed [ACC_W:0]   sum_wide;
    logic signed [ACC_W-1:0] acc_upd;
    logic                    ovf_upd;
    logic                    emit;

    // signed 32x32 product, sign-extended to the accumulator width
    always_comb
    begin
        if (item.is_nz && item.in_range)
        begin
            prod_next = $signed(item.value) * x;
        end
        else
        begin
            prod_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        p_nz_reg   <= item.is_nz;
        p_end_reg  <= item.row_end;
        p_last_reg <= item.last_row;
        prod_reg   <= prod_next;
    end

    assign sum_wide = {acc_reg[ACC_W-1], acc_reg} + {prod_reg[ACC_W-1], prod_reg};

    always_comb
    begin
        if (!p_nz_reg)
        begin
            // empty row reports a clean zero
            acc_upd = '0;
            ovf_upd = 1'b0;
        end
        else if (sum_wide[ACC_W] != sum_wide[ACC_W-1])
        begin
            acc_upd = sum_wide[ACC_W] ? ACC_MIN : ACC_MAX;
            ovf_upd = 1'b1;
        end
        else
        begin
            acc_upd = sum_wide[ACC_W-1:0];
            ovf_upd = ovf_reg;
        end
    end

    assign emit     = p_valid_reg && (!p_nz_reg || p_end_reg);
    assign cnt_next = p_last_reg ? '0 :
                      (cnt_reg == RW'(MAX_ROWS - 1)) ? '0 : cnt_reg + 1'b1;
    assign cnt_wide = IW'(cnt_reg);

    always_comb
    begin
        fin_next.valid     = emit;
        fin_next.row_index = cnt_wide[ROWIDX_W-1:0];
        fin_next.acc       = acc_upd;
        fin_next.ovf       = ovf_upd;
        fin_next.last      = p_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            ovf_reg <= 1'b0;
            cnt_reg <= '0;
            fin_reg <= '0;
        end
        else
        begin
            fin_reg <= fin_next;
            if (p_valid_reg)
            begin
                if (emit)
                begin
                    acc_reg <= '0;
                    ovf_reg <= 1'b0;
                    cnt_reg <= cnt_next;
                end
                else
                begin
                    acc_reg <= acc_upd;
                    ovf_reg <= ovf_upd;
                end
            end
        end
    end

    assign prod_valid = p_valid_reg;
    assign fin        = fin_reg;

endmodule

// ===== hdl/smvm_round.sv =====
// ---------------------------------------------------------------------------
// smvm_round
// Floor of a Q32.32 row sum to Q16.16 with 32-bit saturation.
// ---------------------------------------------------------------------------
module smvm_round (
    input  smvm_pkg::fin_t  fin,
    output smvm_pkg::beat_t beat
);
    import smvm_pkg::*;

    localparam int Q_W = ACC_W - 16;

    logic [Q_W-1:0]     q;
    logic [Q_W-VAL_W:0] q_hi;
    logic               clip;

    // arithmetic shift right by 16 is the floor
    assign q    = fin.acc[ACC_W-1:16];
    assign q_hi = q[Q_W-1:VAL_W-1];
    assign clip = !((q_hi == '0) || (q_hi == '1));

    always_comb
    begin
        beat.row_index = fin.row_index;
        beat.last      = fin.last;
        beat.saturated = clip || fin.ovf;
        if (clip)
        begin
            beat.row_sum = q[Q_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        end
        else
        begin
            beat.row_sum = q[VAL_W-1:0];
        end
    end

endmodule

// ===== hdl/smvm_out_fifo.sv =====
// ---------------------------------------------------------------------------
// smvm_out_fifo
// Small result queue between the pipeline and the master port.
// ---------------------------------------------------------------------------
module smvm_out_fifo (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  smvm_pkg::beat_t            push_beat,
    input  logic                       pop,
    output logic                       out_valid,
    output smvm_pkg::beat_t            out_beat,
    output logic [smvm_pkg::FIFO_AW:0] count
);
    import smvm_pkg::*;

    beat_t              slot [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg;
    logic               do_pop;

    assign do_pop = pop && (count_reg != '0);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot[wr_ptr_reg] <= push_beat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!push && do_pop)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign out_valid = (count_reg != '0);
    assign out_beat  = slot[rd_ptr_reg];
    assign count     = count_reg;

endmodule

// ===== hdl/smvm_checker.sv =====
// ---------------------------------------------------------------------------
// smvm_checker
// Port-level checks of the sparse matrix-vector multiply block.
// ---------------------------------------------------------------------------
`include "sparse_matrix_vector_multiply_macros.svh"

module smvm_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [smvm_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [smvm_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                             m_axis_tuser,
    input logic                             m_axis_tlast
);
    import smvm_pkg::*;

    logic                   in_row_beat;
    logic [OUT_TDATA_W+1:0] out_payload;

    assign in_row_beat = s_axis_tvalid && s_axis_tready
                       && (s_axis_tuser[1:0] inside {KIND_NZ, KIND_EMPTY});
    assign out_payload = {m_axis_tuser, m_axis_tlast, m_axis_tdata};

    // stalled result beat keeps its payload and its valid
    `SMVM_ASSERT_HOLD(a_out_hold, m_axis_tvalid, m_axis_tready, out_payload, "result beat changed while stalled")
    `SMVM_ASSERT_HOLD(a_out_valid_hold, m_axis_tvalid, m_axis_tready, m_axis_tvalid, "result valid dropped")

    // with the result queue empty there is always room for a new beat
    `SMVM_ASSERT(a_ready_when_empty, !m_axis_tvalid |-> s_axis_tready, "input stalled with empty queue")

    // a result into an empty queue comes from a row beat accepted earlier
    `SMVM_ASSERT(a_result_source, $rose(m_axis_tvalid) |-> $past(in_row_beat, 4), "result without input beat")

endmodule

bind sparse_matrix_vector_multiply smvm_checker u_smvm_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Checks the sparse matrix-vector multiply block. Vector loads and CSR rows
// go in on the slave stream, and each row sum out of the master stream is
// compared against a fixed-point row predictor kept in a scoreboard. The run
// goes through three idling phases and includes one long receiver hold-off.
// ---------------------------------------------------------------------------
module testbench;

    import smvm_pkg::*;

    localparam logic [1:0] KIND_UNUSED  = 2'd3;
    localparam int         CYCLE_LIMIT  = 400000;
    localparam int         PIPE_LATENCY = 4;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         PHASE_ITEMS  = 560;
    localparam int         MAX_REPORTS  = 100;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // col_index, entry_value
    logic [IN_TUSER_W-1:0]  s_axis_tuser;   // kind, last_row
    logic                   s_axis_tlast;   // row_end
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // row_index, row_sum
    logic                   m_axis_tuser;   // saturated
    logic                   m_axis_tlast;   // last

    // predicts the row sums and holds them until the matching beat comes out
    class row_scoreboard;
        localparam longint ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
        localparam longint ACC_MIN = 64'sh8000_0000_0000_0000;
        localparam longint SUM_MAX = 64'sh0000_0000_7FFF_FFFF;
        localparam longint SUM_MIN = 64'shFFFF_FFFF_8000_0000;

        logic [VAL_W-1:0]    x_vec [1024];
        longint              acc = 0;
        bit                  acc_clipped = 0;
        logic [ROWIDX_W-1:0] row_cnt = '0;
        beat_t               expected_rows [$];
        int                  errors = 0;

        function void advance_row(input logic final_row);
            acc = 0;
            acc_clipped = 0;
            row_cnt = final_row ? '0 : row_cnt + 1'b1;
        endfunction

        function void note_input(input logic [1:0] kind, input logic [COL_W-1:0] col,
                                 input logic signed [VAL_W-1:0] val,
                                 input logic row_end, input logic last_row);
            longint prod;
            longint q;
            beat_t  row;
            case (kind)
                KIND_LOAD:
                    x_vec[col] = val;
                KIND_NZ:
                begin
                    prod = longint'(val) * longint'($signed(x_vec[col]));
                    if (prod > 0 && acc > ACC_MAX - prod)
                    begin
                        acc = ACC_MAX;
                        acc_clipped = 1;
                    end
                    else if (prod < 0 && acc < ACC_MIN - prod)
                    begin
                        acc = ACC_MIN;
                        acc_clipped = 1;
                    end
                    else
                        acc = acc + prod;
                    if (row_end)
                    begin
                        // floor to Q16.16, then clip to 32 bits
                        q = acc >>> 16;
                        row.row_index = row_cnt;
                        row.saturated = acc_clipped;
                        row.last      = last_row;
                        if (q > SUM_MAX)
                        begin
                            row.row_sum   = 32'h7FFF_FFFF;
                            row.saturated = 1'b1;
                        end
                        else if (q < SUM_MIN)
                        begin
                            row.row_sum   = 32'h8000_0000;
                            row.saturated = 1'b1;
                        end
                        else
                            row.row_sum = q[31:0];
                        expected_rows.push_back(row);
                        advance_row(last_row);
                    end
                end
                KIND_EMPTY:
                begin
                    row.row_index = row_cnt;
                    row.row_sum   = '0;
                    row.saturated = 1'b0;
                    row.last      = last_row;
                    expected_rows.push_back(row);
                    advance_row(last_row);
                end
                default:
                    ;
            endcase
        endfunction

        function void report(input string field, input logic [63:0] exp_val,
                             input logic [63:0] got_val);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %h, actual %h",
                         $time, field, exp_val, got_val);
        endfunction

        function void check_result(input beat_t got);
            beat_t exp_row;
            if (expected_rows.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected beat, expected none, actual %h", $time, got);
                return;
            end
            exp_row = expected_rows.pop_front();
            if (got.row_index !== exp_row.row_index)
                report("row_index", exp_row.row_index, got.row_index);
            if (got.row_sum !== exp_row.row_sum)
                report("row_sum", exp_row.row_sum, got.row_sum);
            if (got.saturated !== exp_row.saturated)
                report("saturated", exp_row.saturated, got.saturated);
            if (got.last !== exp_row.last)
                report("last", exp_row.last, got.last);
        endfunction

        function int pending();
            return expected_rows.size();
        endfunction
    endclass

    row_scoreboard sb;
    int            src_idle_pct;
    int            sink_idle_pct;
    int            hold_reqs;
    int            items_sent;
    int            cycle_count;
    int            written_cols [$];
    bit            col_written [1024];

    sparse_matrix_vector_multiply uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver: random stalls plus a long hold-off whenever one is requested
    initial
    begin
        int hold_done;
        int hold_left;
        hold_done = 0;
        hold_left = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_reqs != hold_done)
            begin
                hold_done++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready = 1'b0;
            end
            else
                m_axis_tready = ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        beat_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.row_index = m_axis_tdata[ROWIDX_W-1:0];
            got.row_sum   = m_axis_tdata[ROWIDX_W+VAL_W-1:ROWIDX_W];
            got.saturated = m_axis_tuser;
            got.last      = m_axis_tlast;
            sb.check_result(got);
        end
    end

    // one beat on the slave stream; returns at the edge that accepts it
    task automatic send_item(input logic [1:0] kind, input logic [COL_W-1:0] col,
                             input logic [VAL_W-1:0] val, input logic row_end,
                             input logic last_row);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {{(IN_TDATA_W-COL_W-VAL_W){1'b0}}, val, col};
        s_axis_tuser  = {last_row, kind};
        s_axis_tlast  = row_end;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_input(kind, col, val, row_end, last_row);
        if (kind != KIND_UNUSED)
            items_sent++;
    endtask

    task automatic load_entry(input logic [COL_W-1:0] col, input logic [VAL_W-1:0] val);
        send_item(KIND_LOAD, col, val, 1'b0, 1'b0);
        if (!col_written[col])
        begin
            col_written[col] = 1;
            written_cols.push_back(int'(col));
        end
    endtask

    function automatic logic [VAL_W-1:0] rand_value();
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return $urandom_range(32'h0004_0000) - 32'h0002_0000;
            5, 6:          return $urandom;
            7:             return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default:       return $urandom_range(1) ? 32'h0001_0000 : 32'hFFFF_0000;
        endcase
    endfunction

    initial
    begin
        int       nrows;
        int       nnz;
        int       target;
        logic     final_row;
        logic [9:0] col;
        sb = new();
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        s_axis_tlast  = 1'b0;
        src_idle_pct  = 18;
        sink_idle_pct = 79;
        hold_reqs     = 0;
        items_sent    = 0;
        cycle_count   = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: vector extremes, clipping both ways, floor, empty rows, noise
        load_entry(10'd0,    32'h7FFF_FFFF);
        load_entry(10'd1023, 32'h8000_0000);
        load_entry(10'd1,    32'h0001_0000);
        load_entry(10'd2,    32'hFFFF_FFFF);
        load_entry(10'd3,    32'h0000_0000);
        send_item(KIND_NZ, 10'd1, 32'h0001_8000, 1'b1, 1'b0);
        send_item(KIND_NZ, 10'd0, 32'h7FFF_FFFF, 1'b1, 1'b0);     // rounding clip high
        send_item(KIND_NZ, 10'd1023, 32'h8000_0000, 1'b0, 1'b0);
        send_item(KIND_NZ, 10'd1023, 32'h8000_0000, 1'b0, 1'b0);  // accumulator clip high
        send_item(KIND_NZ, 10'd3, 32'h1234_5678, 1'b1, 1'b0);
        send_item(KIND_NZ, 10'd0, 32'h8000_0000, 1'b1, 1'b0);     // rounding clip low
        send_item(KIND_NZ, 10'd2, 32'h0000_0001, 1'b1, 1'b0);     // tiny negative floors to -1
        send_item(KIND_NZ, 10'd1, 32'h0000_0005, 1'b0, 1'b1);     // last_row without row end
        load_entry(10'd4, 32'h0000_0007);                        // load inside an open row
        send_item(KIND_EMPTY, 10'd0, 32'h0000_0000, 1'b0, 1'b0); // drops the partial sum
        send_item(KIND_UNUSED, 10'h3FF, 32'hFFFF_FFFF, 1'b1, 1'b1);
        send_item(KIND_NZ, 10'd4, 32'h0000_0002, 1'b1, 1'b1);
        send_item(KIND_EMPTY, 10'h2AA, 32'hFFFF_FFFF, 1'b1, 1'b1);
        send_item(KIND_NZ, 10'd1023, 32'h7FFF_FFFF, 1'b0, 1'b0);
        send_item(KIND_NZ, 10'd1023, 32'h7FFF_FFFF, 1'b0, 1'b0);
        send_item(KIND_NZ, 10'd1023, 32'h7FFF_FFFF, 1'b1, 1'b1);  // accumulator clip low

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    src_idle_pct  = 18;
                    sink_idle_pct = 79;
                end
                1:
                begin
                    src_idle_pct  = 79;
                    sink_idle_pct = 18;
                end
                default:
                begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                    hold_reqs++;    // long hold-off: the block fills and stalls its input
                end
            endcase
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
            begin
                repeat ($urandom_range(0, 12))
                    load_entry(COL_W'($urandom_range(1023)), rand_value());
                nrows = $urandom_range(1, 10);
                for (int r = 0; r < nrows; r++)
                begin
                    // now and then the final row is left unflagged
                    final_row = (r == nrows - 1) && ($urandom_range(7) != 0);
                    if ($urandom_range(9) == 0)
                    begin
                        send_item(KIND_EMPTY, COL_W'($urandom_range(1023)), $urandom,
                                  1'($urandom_range(1)), final_row);
                        continue;
                    end
                    nnz = $urandom_range(1, 6);
                    for (int k = 0; k < nnz; k++)
                    begin
                        case ($urandom_range(24))
                            0: send_item(KIND_UNUSED, COL_W'($urandom_range(1023)), $urandom,
                                         1'($urandom_range(1)), 1'($urandom_range(1)));
                            1: load_entry(COL_W'($urandom_range(1023)), rand_value());
                            2: if (k > 0)
                                   send_item(KIND_EMPTY, COL_W'($urandom_range(1023)), $urandom,
                                             1'($urandom_range(1)), 1'b0);
                            default: ;
                        endcase
                        col = COL_W'(written_cols[$urandom_range(written_cols.size() - 1)]);
                        if (k == nnz - 1)
                            send_item(KIND_NZ, col, rand_value(), 1'b1, final_row);
                        else
                            send_item(KIND_NZ, col, rand_value(), 1'b0, 1'($urandom_range(1)));
                    end
                end
            end
        end

        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4 * PIPE_LATENCY) @(posedge clk);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/smvm_pkg.sv
hdl/smvm_vec_mem.sv
hdl/smvm_mac.sv
hdl/smvm_round.sv
hdl/smvm_out_fifo.sv
hdl/sparse_matrix_vector_multiply.sv
hdl/smvm_checker.sv
tb/testbench.sv
